// File: hw/rtl/trpu_pkg.sv
// Shared types, constants and helper functions for the tracked robot pose update block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package trpu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_FLOOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_OFFSET = 2'd2;

  localparam logic [7:0]  PWM_FLOOR_RST    = 8'd70;
  localparam logic [17:0] SPEED_MAX_RST    = 18'd19661;
  localparam logic [15:0] TRACK_OFFSET_RST = 16'd6554;

  localparam logic [22:0] CHARGE_FULL = 23'd6553600;
  localparam logic [23:0] QUARTER     = 24'h400000;
  localparam logic [23:0] HALF_QUAD   = 24'h200000;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] ATAN_UNIT   = 32'd683565276;
  localparam logic [25:0] TURN_K      = 26'd54396419;

  // Counter width of the rotation iterations (up to 32 of them).
  localparam int ROT_CNT_W = 6;

  localparam logic [31:0] ATAN_TAB [13] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886
  };

  typedef struct packed {
    logic [7:0]  duty_left;
    logic [7:0]  duty_right;
    logic        forward_left;
    logic        forward_right;
    logic [15:0] step_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [23:0]        heading;
    logic [22:0]        battery_level;
  } out_t;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic       start;
    mdu_op_t    op;
    logic [6:0] cnt;
  } mdu_req_t;

  // Arctangent of 2^-idx in units of 2^-32 turn.
  function automatic logic [31:0] atan_step(input logic [4:0] idx);
    logic [32:0] v;
    if (idx < 5'd13) begin
      v = {1'b0, ATAN_TAB[idx[3:0]]};
    end else begin
      v = ({1'b0, ATAN_UNIT} + (33'd1 << (idx - 5'd1))) >> idx;
    end
    return v[31:0];
  endfunction

  // Signed shift right by sh with rounding half away from zero.
  function automatic logic [63:0] scale_round(input logic [63:0] v, input int unsigned sh);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? (64'd0 - m) : m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/trpu_mdu.sv
// Shared bit-serial multiply and restoring divide unit, one bit per cycle.
// Depends on trpu_pkg for the request type.
`default_nettype none

module trpu_mdu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire trpu_pkg::mdu_req_t req,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  output logic                    done,
  output logic [63:0]             res
);

  logic              busy_r;
  logic              done_r;
  trpu_pkg::mdu_op_t op_r;
  logic [6:0]        cnt_r;
  logic [63:0]       sh_r;
  logic [63:0]       b_r;
  logic [63:0]       acc_r;
  logic [64:0]       rem_r;
  logic [64:0]       rem_try;
  logic              fits;

  assign rem_try = {rem_r[63:0], sh_r[63]};
  assign fits    = rem_try >= {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= req.cnt;
        b_r    <= b;
        acc_r  <= '0;
        rem_r  <= '0;
        if (req.op == trpu_pkg::MDU_DIV) begin
          sh_r <= a << (7'd64 - req.cnt);
        end else begin
          sh_r <= a;
        end
      end else if (busy_r) begin
        unique case (op_r)
          trpu_pkg::MDU_MUL: begin
            if (b_r[0]) begin
              acc_r <= acc_r + sh_r;
            end
            sh_r <= sh_r << 1;
            b_r  <= b_r >> 1;
          end
          trpu_pkg::MDU_DIV: begin
            if (fits) begin
              rem_r <= rem_try - {1'b0, b_r};
            end else begin
              rem_r <= rem_try;
            end
            acc_r <= {acc_r[62:0], fits};
            sh_r  <= sh_r << 1;
          end
          default: begin
            acc_r <= acc_r;
          end
        endcase
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/trpu_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a 24-bit turn fraction in Q2.26.
// Depends on trpu_pkg for the gain, the arctangent steps and the rounding helper.
`default_nettype none

module trpu_cordic #(
  parameter int ROTATION_STEPS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [23:0]        angle,
  output logic                    done,
  output logic signed [29:0]      cos_val,
  output logic signed [29:0]      sin_val
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } cstate_t;

  cstate_t                           state_r;
  logic                              done_r;
  logic [trpu_pkg::ROT_CNT_W-1:0]    cnt_r;
  logic [1:0]                        q_r;
  logic signed [33:0]                x_r;
  logic signed [33:0]                y_r;
  logic signed [33:0]                z_r;
  logic signed [29:0]                cos_r;
  logic signed [29:0]                sin_r;

  logic [23:0]        biased;
  logic [1:0]         quad;
  logic [23:0]        zred;
  logic [4:0]         idx;
  logic signed [33:0] step;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic [63:0]        xr;
  logic [63:0]        yr;

  assign biased = angle + trpu_pkg::HALF_QUAD;
  assign quad   = biased[23:22];
  assign zred   = angle - {quad, 22'd0};
  assign idx    = cnt_r[4:0];
  assign step   = 34'(trpu_pkg::atan_step(idx));
  assign xs     = x_r >>> idx;
  assign ys     = y_r >>> idx;

  // Undo the quadrant reduction.
  always_comb begin
    unique case (q_r)
      2'd1: begin
        xf = -y_r;
        yf = x_r;
      end
      2'd2: begin
        xf = -x_r;
        yf = -y_r;
      end
      2'd3: begin
        xf = y_r;
        yf = -x_r;
      end
      default: begin
        xf = x_r;
        yf = y_r;
      end
    endcase
  end

  assign xr = trpu_pkg::scale_round(64'(xf), 4);
  assign yr = trpu_pkg::scale_round(64'(yf), 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            q_r     <= quad;
            z_r     <= {{2{zred[23]}}, zred, 8'd0};
            x_r     <= 34'(trpu_pkg::CORDIC_GAIN);
            y_r     <= '0;
            cnt_r   <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_r[33]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - step;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + step;
          end
          cnt_r <= cnt_r + trpu_pkg::ROT_CNT_W'(1);
          if (cnt_r == trpu_pkg::ROT_CNT_W'(ROTATION_STEPS - 1)) begin
            state_r <= C_FIN;
          end
        end
        C_FIN: begin
          cos_r   <= xr[29:0];
          sin_r   <= yr[29:0];
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

`default_nettype wire

// File: hw/rtl/tracked_robot_pose_update_top.sv
// Tracked robot pose and battery tracker: one transaction in, one pose result out.
// Processing time is set by the shared bit-serial multiply/divide unit (one bit per cycle)
// and the iterative CORDIC; the arc branch takes longer than the straight branch.
// A new transaction is taken only after the previous result has entered the output slot.
// Reset (synchronous, active low) sets pose to zero, heading to zero, charge to 100 percent
// and the configuration registers to their defaults.
`default_nettype none

module tracked_robot_pose_update_top #(
  parameter int ROTATION_STEPS = 20,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire trpu_pkg::in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output trpu_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [trpu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [trpu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // The sequencer walks through the speed calculation, then either the straight branch
  // (travel along the heading) or the arc branch (radius, turn angle, two rotations).
  typedef enum logic [4:0] {
    S_IDLE,
    S_LM,
    S_LD,
    S_RM,
    S_RD,
    S_CLS,
    S_SM,
    S_SC,
    S_SX,
    S_SY,
    S_AN,
    S_AR,
    S_AT,
    S_AK,
    S_AD,
    S_AC1,
    S_AC2,
    S_AX,
    S_AY,
    S_UPD
  } state_t;

  // Configuration registers.
  logic [7:0]  floor_r;
  logic [17:0] smax_r;
  logic [15:0] toff_r;

  // Pose and battery state.
  logic [POSITION_WIDTH-1:0] xpos_r;
  logic [POSITION_WIDTH-1:0] ypos_r;
  logic [23:0]               head_r;
  logic [22:0]               charge_r;

  // Sequencer registers.
  state_t             state_r;
  logic               go_r;
  trpu_pkg::in_t      item_r;
  logic [17:0]        spd_l_r;
  logic [17:0]        spd_r_r;
  logic               arc_r;
  logic signed [19:0] dv_r;
  logic signed [19:0] sum_r;
  logic [63:0]        tmp_r;
  logic [35:0]        mag_r;
  logic               mneg_r;
  logic signed [29:0] c1_r;
  logic signed [29:0] s1_r;
  logic signed [29:0] c2_r;
  logic signed [29:0] s2_r;
  logic [23:0]        delta_r;
  logic [63:0]        dx_r;
  logic [63:0]        dy_r;
  trpu_pkg::out_t     out_r;
  logic               out_valid_r;

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= trpu_pkg::PWM_FLOOR_RST;
      smax_r  <= trpu_pkg::SPEED_MAX_RST;
      toff_r  <= trpu_pkg::TRACK_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trpu_pkg::CFG_PWM_FLOOR:    floor_r <= cfg_wdata[7:0];
        trpu_pkg::CFG_SPEED_MAX:    smax_r  <= cfg_wdata[17:0];
        trpu_pkg::CFG_TRACK_OFFSET: toff_r  <= cfg_wdata[15:0];
        default: begin
          floor_r <= floor_r;
        end
      endcase
    end
  end

  // Signed track speeds and their sum and difference, formed in the classify step.
  logic signed [19:0] vl;
  logic signed [19:0] vr;
  logic signed [19:0] dv_c;
  logic signed [19:0] sum_c;
  logic [19:0]        adv_c;
  logic [29:0]        adv_k;
  logic               straight_c;

  assign vl    = item_r.forward_left ? signed'({2'b00, spd_l_r}) : -signed'({2'b00, spd_l_r});
  assign vr    = item_r.forward_right ? signed'({2'b00, spd_r_r}) : -signed'({2'b00, spd_r_r});
  assign dv_c  = vl - vr;
  assign sum_c = vl + vr;
  assign adv_c = dv_c[19] ? 20'(-dv_c) : 20'(dv_c);
  // 1000 * |dv| as shifts and adds.
  assign adv_k = {adv_c, 10'd0} - 30'({adv_c, 4'd0}) - 30'({adv_c, 3'd0});
  assign straight_c = (dv_c == 20'sd0) || (adv_k < 30'(smax_r));

  // Magnitudes taken from the registered sum and difference.
  logic [19:0] adv;
  logic [19:0] sum_mag;
  logic [15:0] offs;
  logic        zero_l;
  logic        zero_r;

  assign adv     = dv_r[19] ? 20'(-dv_r) : 20'(dv_r);
  assign sum_mag = sum_r[19] ? 20'(-sum_r) : 20'(sum_r);
  // A zero track offset counts as one.
  assign offs    = (toff_r == 16'd0) ? 16'd1 : toff_r;
  // A track whose duty is at or below the floor stands still, as do both when the floor is full.
  assign zero_l  = (floor_r == 8'hFF) || (item_r.duty_left <= floor_r);
  assign zero_r  = (floor_r == 8'hFF) || (item_r.duty_right <= floor_r);

  logic signed [30:0] dc;
  logic signed [30:0] ds;
  logic [29:0]        c1_mag;
  logic [29:0]        s1_mag;
  logic [30:0]        dc_mag;
  logic [30:0]        ds_mag;

  assign c1_mag = c1_r[29] ? 30'(-c1_r) : 30'(c1_r);
  assign s1_mag = s1_r[29] ? 30'(-s1_r) : 30'(s1_r);
  assign dc     = 31'(c2_r) - 31'(c1_r);
  assign ds     = 31'(s2_r) - 31'(s1_r);
  assign dc_mag = dc[30] ? 31'(-dc) : 31'(dc);
  assign ds_mag = ds[30] ? 31'(-ds) : 31'(ds);

  // Request to the shared multiply/divide unit for the current step.
  trpu_pkg::mdu_req_t mdu_req;
  logic [63:0]        mdu_a;
  logic [63:0]        mdu_b;
  logic               mdu_done;
  logic [63:0]        mdu_res;
  logic               uses_mdu;

  always_comb begin
    uses_mdu    = 1'b1;
    mdu_req.op  = trpu_pkg::MDU_MUL;
    mdu_req.cnt = 7'd1;
    mdu_a       = '0;
    mdu_b       = '0;
    unique case (state_r)
      S_LM: begin
        mdu_a       = 64'(smax_r);
        mdu_b       = 64'(item_r.duty_left - floor_r);
        mdu_req.cnt = 7'd8;
      end
      S_LD: begin
        mdu_req.op  = trpu_pkg::MDU_DIV;
        mdu_a       = tmp_r;
        mdu_b       = 64'(8'd255 - floor_r);
        mdu_req.cnt = 7'd26;
      end
      S_RM: begin
        mdu_a       = 64'(smax_r);
        mdu_b       = 64'(item_r.duty_right - floor_r);
        mdu_req.cnt = 7'd8;
      end
      S_RD: begin
        mdu_req.op  = trpu_pkg::MDU_DIV;
        mdu_a       = tmp_r;
        mdu_b       = 64'(8'd255 - floor_r);
        mdu_req.cnt = 7'd26;
      end
      S_SM: begin
        mdu_a       = 64'(sum_mag);
        mdu_b       = 64'(item_r.step_time);
        mdu_req.cnt = 7'd16;
      end
      S_SX: begin
        mdu_a       = 64'(mag_r);
        mdu_b       = 64'(c1_mag);
        mdu_req.cnt = 7'd28;
      end
      S_SY: begin
        mdu_a       = 64'(mag_r);
        mdu_b       = 64'(s1_mag);
        mdu_req.cnt = 7'd28;
      end
      S_AN: begin
        mdu_a       = 64'(sum_mag);
        mdu_b       = 64'(offs);
        mdu_req.cnt = 7'd16;
      end
      S_AR: begin
        mdu_req.op  = trpu_pkg::MDU_DIV;
        mdu_a       = tmp_r;
        mdu_b       = 64'(adv);
        mdu_req.cnt = 7'd36;
      end
      S_AT: begin
        mdu_a       = 64'(adv);
        mdu_b       = 64'(item_r.step_time);
        mdu_req.cnt = 7'd16;
      end
      S_AK: begin
        mdu_a       = tmp_r;
        mdu_b       = 64'(trpu_pkg::TURN_K);
        mdu_req.cnt = 7'd26;
      end
      S_AD: begin
        // Dividing by D * 2^24 is the same as dropping 24 bits and dividing by D.
        mdu_req.op  = trpu_pkg::MDU_DIV;
        mdu_a       = tmp_r >> 24;
        mdu_b       = 64'(offs);
        mdu_req.cnt = 7'd37;
      end
      S_AX: begin
        mdu_a       = 64'(mag_r);
        mdu_b       = 64'(dc_mag);
        mdu_req.cnt = 7'd30;
      end
      S_AY: begin
        mdu_a       = 64'(mag_r);
        mdu_b       = 64'(ds_mag);
        mdu_req.cnt = 7'd30;
      end
      default: begin
        uses_mdu = 1'b0;
      end
    endcase
    mdu_req.start = go_r && uses_mdu;
  end

  trpu_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .a     (mdu_a),
    .b     (mdu_b),
    .done  (mdu_done),
    .res   (mdu_res)
  );

  // Rotation unit: heading for the straight branch, heading less a quarter turn and that
  // angle plus the turn for the arc branch.
  logic [23:0]        rot;
  logic [23:0]        cor_angle;
  logic               cor_start;
  logic               cor_done;
  logic signed [29:0] cor_cos;
  logic signed [29:0] cor_sin;

  assign rot       = head_r - trpu_pkg::QUARTER;
  assign cor_angle = (state_r == S_SC) ? head_r :
                     (state_r == S_AC1) ? rot : rot + delta_r;
  assign cor_start = go_r && ((state_r == S_SC) || (state_r == S_AC1) || (state_r == S_AC2));

  trpu_cordic #(
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_val (cor_cos),
    .sin_val (cor_sin)
  );

  // Product with its sign applied, wrapping at 64 bits, then rounded to Q16.16.
  logic        sx_neg;
  logic        sy_neg;
  logic        ax_neg;
  logic        ay_neg;
  logic [63:0] neg_res;
  logic [63:0] sx_step;
  logic [63:0] sy_step;
  logic [63:0] ax_step;
  logic [63:0] ay_step;

  assign sx_neg  = mneg_r ^ c1_r[29];
  assign sy_neg  = mneg_r ^ s1_r[29];
  assign ax_neg  = mneg_r ^ dc[30];
  assign ay_neg  = mneg_r ^ ds[30];
  assign neg_res = 64'd0 - mdu_res;
  assign sx_step = trpu_pkg::scale_round(sx_neg ? neg_res : mdu_res, 43);
  assign sy_step = trpu_pkg::scale_round(sy_neg ? neg_res : mdu_res, 43);
  assign ax_step = trpu_pkg::scale_round(ax_neg ? neg_res : mdu_res, 26);
  assign ay_step = trpu_pkg::scale_round(ay_neg ? neg_res : mdu_res, 26);

  // Final update of pose and battery.
  logic [POSITION_WIDTH-1:0] xpos_nxt;
  logic [POSITION_WIDTH-1:0] ypos_nxt;
  logic [23:0]               head_nxt;
  logic [24:0]               drain_full;
  logic [15:0]               drain;
  logic [22:0]               charge_nxt;
  logic                      slot_free;

  assign xpos_nxt   = xpos_r + dx_r[POSITION_WIDTH-1:0];
  assign ypos_nxt   = ypos_r + dy_r[POSITION_WIDTH-1:0];
  assign head_nxt   = arc_r ? head_r + delta_r : head_r;
  assign drain_full = 25'(item_r.step_time) *
                      25'(9'(item_r.duty_left) + 9'(item_r.duty_right));
  assign drain      = drain_full[24:9];
  assign charge_nxt = (charge_r > 23'(drain)) ? charge_r - 23'(drain) : 23'd0;
  assign slot_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      xpos_r      <= '0;
      ypos_r      <= '0;
      head_r      <= '0;
      charge_r    <= trpu_pkg::CHARGE_FULL;
    end else begin
      go_r <= 1'b0;
      // In the update state a taken result is replaced by the new one below.
      if (out_valid_r && out_ready && (state_r != S_UPD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            go_r    <= 1'b1;
            state_r <= S_LM;
          end
        end
        S_LM: begin
          if (mdu_done) begin
            tmp_r   <= mdu_res;
            go_r    <= 1'b1;
            state_r <= S_LD;
          end
        end
        S_LD: begin
          if (mdu_done) begin
            spd_l_r <= zero_l ? 18'd0 : mdu_res[17:0];
            go_r    <= 1'b1;
            state_r <= S_RM;
          end
        end
        S_RM: begin
          if (mdu_done) begin
            tmp_r   <= mdu_res;
            go_r    <= 1'b1;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (mdu_done) begin
            spd_r_r <= zero_r ? 18'd0 : mdu_res[17:0];
            state_r <= S_CLS;
          end
        end
        S_CLS: begin
          dv_r  <= dv_c;
          sum_r <= sum_c;
          arc_r <= !straight_c;
          go_r  <= 1'b1;
          if (straight_c) begin
            state_r <= S_SM;
          end else begin
            state_r <= S_AN;
          end
        end
        S_SM: begin
          if (mdu_done) begin
            mag_r   <= mdu_res[35:0];
            mneg_r  <= sum_r[19];
            go_r    <= 1'b1;
            state_r <= S_SC;
          end
        end
        S_SC: begin
          if (cor_done) begin
            c1_r    <= cor_cos;
            s1_r    <= cor_sin;
            go_r    <= 1'b1;
            state_r <= S_SX;
          end
        end
        S_SX: begin
          if (mdu_done) begin
            dx_r    <= sx_step;
            go_r    <= 1'b1;
            state_r <= S_SY;
          end
        end
        S_SY: begin
          if (mdu_done) begin
            dy_r    <= sy_step;
            state_r <= S_UPD;
          end
        end
        S_AN: begin
          if (mdu_done) begin
            tmp_r   <= mdu_res;
            mneg_r  <= sum_r[19] ^ dv_r[19];
            go_r    <= 1'b1;
            state_r <= S_AR;
          end
        end
        S_AR: begin
          if (mdu_done) begin
            mag_r   <= mdu_res[35:0];
            go_r    <= 1'b1;
            state_r <= S_AT;
          end
        end
        S_AT: begin
          if (mdu_done) begin
            tmp_r   <= mdu_res;
            go_r    <= 1'b1;
            state_r <= S_AK;
          end
        end
        S_AK: begin
          if (mdu_done) begin
            tmp_r   <= mdu_res;
            go_r    <= 1'b1;
            state_r <= S_AD;
          end
        end
        S_AD: begin
          if (mdu_done) begin
            delta_r <= dv_r[19] ? 24'd0 - mdu_res[23:0] : mdu_res[23:0];
            go_r    <= 1'b1;
            state_r <= S_AC1;
          end
        end
        S_AC1: begin
          if (cor_done) begin
            c1_r    <= cor_cos;
            s1_r    <= cor_sin;
            go_r    <= 1'b1;
            state_r <= S_AC2;
          end
        end
        S_AC2: begin
          if (cor_done) begin
            c2_r    <= cor_cos;
            s2_r    <= cor_sin;
            go_r    <= 1'b1;
            state_r <= S_AX;
          end
        end
        S_AX: begin
          if (mdu_done) begin
            dx_r    <= ax_step;
            go_r    <= 1'b1;
            state_r <= S_AY;
          end
        end
        S_AY: begin
          if (mdu_done) begin
            dy_r    <= ay_step;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          // The result waits here until the output slot is free.
          if (slot_free) begin
            xpos_r              <= xpos_nxt;
            ypos_r              <= ypos_nxt;
            head_r              <= head_nxt;
            charge_r            <= charge_nxt;
            out_r.pos_x         <= signed'(32'(xpos_nxt));
            out_r.pos_y         <= signed'(32'(ypos_nxt));
            out_r.heading       <= head_nxt;
            out_r.battery_level <= charge_nxt;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/trpu_checker.sv
// Port-level checks for the tracked robot pose update block, bound to its top level.
// Depends on trpu_pkg for the result type.
`default_nettype none

module trpu_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire trpu_pkg::out_t out_data
);

  // A transaction keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a transaction");

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result changed or dropped");

  // Reset empties the output slot.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // The battery never reads above full charge.
  a_charge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.battery_level <= 23'd6553600)
    else $error("battery level above full charge");

endmodule

bind tracked_robot_pose_update_top trpu_checker u_trpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
